@@ src/tcp_pkg.sv @@
// Shared types, command and error codes for the tick counter pool.
`default_nettype none
package tcp_pkg;

    // Default pool size.
    localparam int SLOTS_DEFAULT = 64;

    // Field widths of the command and result transactions.
    localparam int CMD_W   = 3;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 32;
    localparam int ERR_W   = 2;
    localparam int GRANT_W = 6;
    localparam int SLEEP_W = 31;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SLEEP   = 3'd5;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

    // Largest sleep countdown.
    localparam logic [SLEEP_W-1:0] SLEEP_MAX = 31'h7FFF_FFFF;

    // One command transaction.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ID_W-1:0]    slot_id;
        logic [COUNT_W-1:0] sleep_ticks;
    } req_t;

    // One result transaction.
    typedef struct packed {
        logic [ERR_W-1:0]   error;
        logic [GRANT_W-1:0] granted_slot;
        logic [COUNT_W-1:0] count_value;
        logic               sleep_busy;
    } res_t;

endpackage
`default_nettype wire

@@ src/tick_counter_pool_top.sv @@
// Top level of the tick counter pool: command channel, engine and result register.
//
// A pool of elapsed-tick counters plus one sleep countdown. Each command
// transaction on the s_ channel (tick, allocate, release, read, clear,
// load sleep) yields exactly one result transaction on the m_ channel.
// A transaction moves when valid and ready are both high at a rising edge.
// Sequence from acceptance to m_valid:
//   tick      the slot RAM is swept one slot a cycle, each write-back
//             landing in the cycle after its read.
//   allocate  the scan reads one slot a cycle from slot zero and checks
//             its flag in the next cycle.
//   read, clear  an id in range takes a RAM read before the result.
//   others    go straight to the result, as do refused ids.
// One command is worked on at a time; s_ready drops while it runs.
// A finished result waits in the output register, and the next command is
// accepted meanwhile; if the receiver stalls, that command completes and
// holds in the engine until the output register frees.
// Synchronous reset (aresetn low) stops the sleep countdown and empties the
// result register; a clearing pass then zeroes every slot's flag and count,
// and s_ready stays low until it ends.
`default_nettype none
module tick_counter_pool_top #(
    parameter int SLOTS = tcp_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [tcp_pkg::CMD_W-1:0]       s_command,
    input  wire logic [tcp_pkg::ID_W-1:0]        s_slot_id,
    input  wire logic [tcp_pkg::COUNT_W-1:0]     s_sleep_ticks,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [tcp_pkg::ERR_W-1:0]       m_error,
    output logic      [tcp_pkg::GRANT_W-1:0]     m_granted_slot,
    output logic      [tcp_pkg::COUNT_W-1:0]     m_count_value,
    output logic                                 m_sleep_busy
);

    tcp_pkg::req_t req;
    tcp_pkg::res_t eng_res;
    tcp_pkg::res_t res_reg;
    logic          eng_res_valid;
    logic          eng_res_ready;
    logic          m_valid_reg;

    assign req.command     = s_command;
    assign req.slot_id     = s_slot_id;
    assign req.sleep_ticks = s_sleep_ticks;

    tcp_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    // Result register parts the engine from the receiver.
    assign eng_res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (eng_res_valid && eng_res_ready) begin
                m_valid_reg <= 1'b1;
                res_reg     <= eng_res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_error        = res_reg.error;
    assign m_granted_slot = res_reg.granted_slot;
    assign m_count_value  = res_reg.count_value;
    assign m_sleep_busy   = res_reg.sleep_busy;

    // A command keeps the engine busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("engine ready right after accepting a command");

    // A failed command never grants a slot.
    a_no_grant_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error != tcp_pkg::ERR_NONE)) |-> (m_granted_slot == '0))
        else $error("slot granted together with an error");

    // A nonzero count comes only with a successful read.
    a_count_needs_success: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_count_value != '0)) |-> (m_error == tcp_pkg::ERR_NONE))
        else $error("count value returned with an error");

    // Only defined error codes appear.
    a_error_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_error == tcp_pkg::ERR_NONE || m_error == tcp_pkg::ERR_FULL ||
                     m_error == tcp_pkg::ERR_RANGE))
        else $error("undefined error code");

endmodule
`default_nettype wire

@@ src/tcp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module tcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ src/tcp_engine.sv @@
// Command sequencer: sleep countdown and read-modify-write of the slot RAM.
`default_nettype none
module tcp_engine #(
    parameter int SLOTS = tcp_pkg::SLOTS_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire tcp_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output tcp_pkg::res_t      res
);

    localparam int IDW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = $clog2(SLOTS + 1);
    // Each RAM word holds the slot's active flag above its count.
    localparam int WW  = tcp_pkg::COUNT_W + 1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_TICK,
        ST_ALLOC,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [tcp_pkg::SLEEP_W-1:0]    sleep_reg, sleep_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic                           wb_valid_reg, wb_valid_next;
    logic [IDW-1:0]                 wb_idx_reg, wb_idx_next;
    logic [IDW-1:0]                 id_reg, id_next;
    logic [tcp_pkg::ERR_W-1:0]      err_reg, err_next;
    logic [tcp_pkg::GRANT_W-1:0]    grant_reg, grant_next;
    logic [tcp_pkg::COUNT_W-1:0]    value_reg, value_next;

    logic                           ram_wr_en;
    logic [IDW-1:0]                 ram_wr_addr;
    logic [WW-1:0]                  ram_wr_data;
    logic                           ram_rd_en;
    logic [IDW-1:0]                 ram_rd_addr;
    logic [WW-1:0]                  ram_rd_data;

    logic                           rd_active;
    logic [tcp_pkg::COUNT_W-1:0]    rd_count;
    logic                           in_range;
    logic [IDW-1:0]                 req_idx;
    logic [IDW-1:0]                 scan_idx;
    logic                           sweep_end;
    logic                           init_last;

    assign rd_active = ram_rd_data[WW-1];
    assign rd_count  = ram_rd_data[tcp_pkg::COUNT_W-1:0];
    assign in_range  = ({1'b0, req.slot_id} < (tcp_pkg::ID_W + 1)'(SLOTS));
    assign req_idx   = req.slot_id[IDW-1:0];
    assign scan_idx  = idx_reg[IDW-1:0];
    assign sweep_end = (idx_reg == CW'(SLOTS));
    assign init_last = (idx_reg == CW'(SLOTS - 1));

    // Per-slot flags and counts live in one RAM.
    tcp_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Next-state logic and RAM port control.
    always_comb begin
        state_next    = state_reg;
        sleep_next    = sleep_reg;
        idx_next      = idx_reg;
        wb_valid_next = 1'b0;
        wb_idx_next   = wb_idx_reg;
        id_next       = id_reg;
        err_next      = err_reg;
        grant_next    = grant_reg;
        value_next    = value_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = wb_idx_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = scan_idx;

        case (state_reg)
            ST_INIT: begin
                // Clearing pass after reset: one slot a cycle.
                ram_wr_en   = 1'b1;
                ram_wr_addr = scan_idx;
                ram_wr_data = '0;
                if (init_last) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_IDLE: begin
                if (req_valid) begin
                    err_next   = tcp_pkg::ERR_NONE;
                    grant_next = '0;
                    value_next = '0;
                    id_next    = req_idx;
                    idx_next   = '0;
                    state_next = ST_DONE;
                    case (req.command)
                        tcp_pkg::CMD_TICK: begin
                            if (sleep_reg != '0) begin
                                sleep_next = sleep_reg - tcp_pkg::SLEEP_W'(1);
                            end
                            state_next = ST_TICK;
                        end
                        tcp_pkg::CMD_ALLOC: begin
                            state_next = ST_ALLOC;
                        end
                        tcp_pkg::CMD_RELEASE: begin
                            if (in_range) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = req_idx;
                                ram_wr_data = '0;
                            end else begin
                                err_next = tcp_pkg::ERR_RANGE;
                            end
                        end
                        tcp_pkg::CMD_READ: begin
                            if (in_range) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = req_idx;
                                state_next  = ST_READ;
                            end else begin
                                err_next = tcp_pkg::ERR_RANGE;
                            end
                        end
                        tcp_pkg::CMD_CLEAR: begin
                            if (in_range) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = req_idx;
                                state_next  = ST_CLEAR;
                            end else begin
                                err_next = tcp_pkg::ERR_RANGE;
                            end
                        end
                        tcp_pkg::CMD_SLEEP: begin
                            sleep_next = req.sleep_ticks[tcp_pkg::COUNT_W-1]
                                       ? tcp_pkg::SLEEP_MAX
                                       : req.sleep_ticks[tcp_pkg::SLEEP_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                // Write back the slot read last cycle, plus one, if it is active.
                ram_wr_en   = wb_valid_reg && rd_active;
                ram_wr_addr = wb_idx_reg;
                ram_wr_data = {1'b1, rd_count + tcp_pkg::COUNT_W'(1)};
                // Read one slot per cycle.
                if (!sweep_end) begin
                    ram_rd_en     = 1'b1;
                    wb_valid_next = 1'b1;
                    wb_idx_next   = scan_idx;
                    idx_next      = idx_reg + CW'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ALLOC: begin
                // Reads run one slot ahead of the free check.
                if (wb_valid_reg && !rd_active) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wb_idx_reg;
                    ram_wr_data = {1'b1, {tcp_pkg::COUNT_W{1'b0}}};
                    grant_next  = tcp_pkg::GRANT_W'(wb_idx_reg);
                    state_next  = ST_DONE;
                end else if (sweep_end) begin
                    err_next   = tcp_pkg::ERR_FULL;
                    state_next = ST_DONE;
                end else begin
                    ram_rd_en     = 1'b1;
                    wb_valid_next = 1'b1;
                    wb_idx_next   = scan_idx;
                    idx_next      = idx_reg + CW'(1);
                end
            end
            ST_READ: begin
                // An inactive slot always reads as zero.
                value_next = rd_active ? rd_count : '0;
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                // Zero the count and keep the slot's flag.
                ram_wr_en   = 1'b1;
                ram_wr_addr = id_reg;
                ram_wr_data = {rd_active, {tcp_pkg::COUNT_W{1'b0}}};
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            sleep_reg    <= '0;
            wb_valid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            sleep_reg    <= sleep_next;
            wb_valid_reg <= wb_valid_next;
            idx_reg      <= idx_next;
            wb_idx_reg   <= wb_idx_next;
            id_reg       <= id_next;
            err_reg      <= err_next;
            grant_reg    <= grant_next;
            value_reg    <= value_next;
        end
    end

    assign req_ready        = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_DONE);
    assign res.error        = err_reg;
    assign res.granted_slot = grant_reg;
    assign res.count_value  = value_reg;
    assign res.sleep_busy   = (sleep_reg != '0);

endmodule
`default_nettype wire

@@ sim/tb_tick_counter_pool_top.sv @@
// Self-checking testbench for the tick counter pool top level.
`timescale 1ns / 100ps
module tb_tick_counter_pool_top;

    localparam int SLOTS = tcp_pkg::SLOTS_DEFAULT;

    // Command codes that the block does not decode.
    localparam logic [tcp_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [tcp_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // Percentage of cycles on which each side idles.
    localparam int IDLE_PCT = 26;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [tcp_pkg::CMD_W-1:0]       s_command = '0;
    logic [tcp_pkg::ID_W-1:0]        s_slot_id = '0;
    logic [tcp_pkg::COUNT_W-1:0]     s_sleep_ticks = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [tcp_pkg::ERR_W-1:0]       m_error;
    logic [tcp_pkg::GRANT_W-1:0]     m_granted_slot;
    logic [tcp_pkg::COUNT_W-1:0]     m_count_value;
    logic                            m_sleep_busy;

    // Shadow copy of the pool, updated as each command transaction is accepted.
    logic                            pool_active [SLOTS];
    logic [tcp_pkg::COUNT_W-1:0]     pool_count [SLOTS];
    logic [tcp_pkg::SLEEP_W-1:0]     sleep_left;

    tcp_pkg::res_t                   pending_results [$];
    int                              idle_pct = IDLE_PCT;
    int                              fail_count = 0;
    int                              checked_count = 0;
    int                              cmd_count [8];
    int                              full_count = 0;
    int                              range_count = 0;

    tick_counter_pool_top #(
        .SLOTS(SLOTS)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_slot_id(s_slot_id),
        .s_sleep_ticks(s_sleep_ticks),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_error(m_error),
        .m_granted_slot(m_granted_slot),
        .m_count_value(m_count_value),
        .m_sleep_busy(m_sleep_busy)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one command to the shadow pool and returns the answer it owes.
    function automatic tcp_pkg::res_t pool_apply(input logic [tcp_pkg::CMD_W-1:0] cmd,
                                                 input logic [tcp_pkg::ID_W-1:0] id,
                                                 input logic [tcp_pkg::COUNT_W-1:0] ticks);
        tcp_pkg::res_t res;
        logic in_range;
        logic found;
        res = '0;
        res.error = tcp_pkg::ERR_NONE;
        in_range = (id < SLOTS);
        found = 1'b0;
        case (cmd)
            tcp_pkg::CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (pool_active[i]) begin
                        pool_count[i] = pool_count[i] + tcp_pkg::COUNT_W'(1);
                    end
                end
                if (sleep_left != '0) begin
                    sleep_left = sleep_left - tcp_pkg::SLEEP_W'(1);
                end
            end
            tcp_pkg::CMD_ALLOC: begin
                // Lowest free slot wins.
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && !pool_active[i]) begin
                        pool_active[i] = 1'b1;
                        res.granted_slot = tcp_pkg::GRANT_W'(i);
                        found = 1'b1;
                    end
                end
                res.error = found ? tcp_pkg::ERR_NONE : tcp_pkg::ERR_FULL;
            end
            tcp_pkg::CMD_RELEASE: begin
                if (in_range) begin
                    pool_active[id] = 1'b0;
                    pool_count[id] = '0;
                end else begin
                    res.error = tcp_pkg::ERR_RANGE;
                end
            end
            tcp_pkg::CMD_READ: begin
                if (in_range) begin
                    res.count_value = pool_count[id];
                end else begin
                    res.error = tcp_pkg::ERR_RANGE;
                end
            end
            tcp_pkg::CMD_CLEAR: begin
                if (in_range) begin
                    pool_count[id] = '0;
                end else begin
                    res.error = tcp_pkg::ERR_RANGE;
                end
            end
            tcp_pkg::CMD_SLEEP: begin
                // Long requests saturate at the largest countdown.
                if (ticks > {1'b0, tcp_pkg::SLEEP_MAX}) begin
                    sleep_left = tcp_pkg::SLEEP_MAX;
                end else begin
                    sleep_left = ticks[tcp_pkg::SLEEP_W-1:0];
                end
            end
            default: begin
            end
        endcase
        res.sleep_busy = (sleep_left != '0);
        return res;
    endfunction

    // Sends one command transaction after an optional random gap and records its answer.
    task automatic send_cmd(input logic [tcp_pkg::CMD_W-1:0] cmd,
                            input logic [tcp_pkg::ID_W-1:0] id,
                            input logic [tcp_pkg::COUNT_W-1:0] ticks);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_slot_id <= id;
        s_sleep_ticks <= ticks;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(pool_apply(cmd, id, ticks));
        cmd_count[cmd]++;
    endtask

    task automatic check_field(input string name, input logic [tcp_pkg::COUNT_W-1:0] want,
                               input logic [tcp_pkg::COUNT_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: random stalls, and each result transaction checked against the oldest answer.
    always @(posedge aclk) begin
        tcp_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("Result transaction arrived with no command outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("error", tcp_pkg::COUNT_W'(want.error),
                            tcp_pkg::COUNT_W'(m_error));
                check_field("granted_slot", tcp_pkg::COUNT_W'(want.granted_slot),
                            tcp_pkg::COUNT_W'(m_granted_slot));
                check_field("count_value", want.count_value, m_count_value);
                check_field("sleep_busy", tcp_pkg::COUNT_W'(want.sleep_busy),
                            tcp_pkg::COUNT_W'(m_sleep_busy));
                checked_count++;
                if (m_error == tcp_pkg::ERR_FULL) begin
                    full_count++;
                end
                if (m_error == tcp_pkg::ERR_RANGE) begin
                    range_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Extremes of each field, every command, and the corner cases one by one.
    task automatic test_directed();
        send_cmd(tcp_pkg::CMD_TICK, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_READ, 8'h00, 32'h0);
        send_cmd(CMD_SPARE_A, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(CMD_SPARE_B, 8'h00, 32'h0000_0001);
        send_cmd(tcp_pkg::CMD_ALLOC, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_ALLOC, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_TICK, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_TICK, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_READ, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_CLEAR, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_READ, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_RELEASE, 8'h01, 32'h0);
        send_cmd(tcp_pkg::CMD_READ, 8'h01, 32'h0);
        send_cmd(tcp_pkg::CMD_ALLOC, 8'h00, 32'h0);
        // Highest valid id, then ids past the end of the pool.
        send_cmd(tcp_pkg::CMD_READ, tcp_pkg::ID_W'(SLOTS - 1), 32'h0);
        send_cmd(tcp_pkg::CMD_READ, tcp_pkg::ID_W'(SLOTS), 32'h0);
        send_cmd(tcp_pkg::CMD_RELEASE, 8'hFF, 32'h0);
        send_cmd(tcp_pkg::CMD_CLEAR, 8'h80, 32'h0);
        // Sleep saturation, reload over a running countdown, and stop by zero.
        send_cmd(tcp_pkg::CMD_SLEEP, 8'h00, 32'hFFFF_FFFF);
        send_cmd(tcp_pkg::CMD_SLEEP, 8'h00, 32'h8000_0000);
        send_cmd(tcp_pkg::CMD_SLEEP, 8'h00, 32'h7FFF_FFFF);
        send_cmd(tcp_pkg::CMD_SLEEP, 8'h00, 32'h0000_0002);
        send_cmd(tcp_pkg::CMD_TICK, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_TICK, 8'h00, 32'h0);
        send_cmd(tcp_pkg::CMD_SLEEP, 8'h00, 32'h0000_0003);
        send_cmd(tcp_pkg::CMD_SLEEP, 8'h00, 32'h0);
    endtask

    // Fills the pool, checks refusals and lowest-free reuse, then empties it again.
    task automatic test_pool_full();
        for (int i = 0; i < SLOTS + 2; i++) begin
            send_cmd(tcp_pkg::CMD_ALLOC, tcp_pkg::ID_W'($urandom), $urandom);
        end
        send_cmd(tcp_pkg::CMD_TICK, tcp_pkg::ID_W'($urandom), $urandom);
        send_cmd(tcp_pkg::CMD_READ, tcp_pkg::ID_W'(SLOTS - 1), $urandom);
        send_cmd(tcp_pkg::CMD_RELEASE, tcp_pkg::ID_W'(SLOTS - 1), $urandom);
        send_cmd(tcp_pkg::CMD_RELEASE, 8'd17, $urandom);
        send_cmd(tcp_pkg::CMD_ALLOC, tcp_pkg::ID_W'($urandom), $urandom);
        send_cmd(tcp_pkg::CMD_ALLOC, tcp_pkg::ID_W'($urandom), $urandom);
        send_cmd(tcp_pkg::CMD_ALLOC, tcp_pkg::ID_W'($urandom), $urandom);
        for (int i = 0; i < SLOTS; i++) begin
            send_cmd(tcp_pkg::CMD_RELEASE, tcp_pkg::ID_W'(i), $urandom);
        end
    endtask

    // Random command mix, with one stretch where neither side idles.
    task automatic test_random(input int n_items);
        logic [tcp_pkg::CMD_W-1:0]   cmd;
        logic [tcp_pkg::ID_W-1:0]    id;
        logic [tcp_pkg::COUNT_W-1:0] ticks;
        int                          pick;
        for (int n = 0; n < n_items; n++) begin
            idle_pct = (n >= 100 && n < 190) ? 0 : IDLE_PCT;
            pick = $urandom_range(99);
            if (pick < 24) begin
                cmd = tcp_pkg::CMD_TICK;
            end else if (pick < 44) begin
                cmd = tcp_pkg::CMD_ALLOC;
            end else if (pick < 58) begin
                cmd = tcp_pkg::CMD_RELEASE;
            end else if (pick < 76) begin
                cmd = tcp_pkg::CMD_READ;
            end else if (pick < 84) begin
                cmd = tcp_pkg::CMD_CLEAR;
            end else if (pick < 93) begin
                cmd = tcp_pkg::CMD_SLEEP;
            end else begin
                cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
            end
            // Mostly valid ids, some anywhere in the 8-bit range.
            if ($urandom_range(99) < 85) begin
                id = tcp_pkg::ID_W'($urandom_range(SLOTS - 1));
            end else begin
                id = tcp_pkg::ID_W'($urandom_range(255));
            end
            // Short countdowns so ticks run them out, plus wide values and the limits.
            pick = $urandom_range(3);
            if (pick < 2) begin
                ticks = $urandom_range(6);
            end else if (pick == 2) begin
                ticks = $urandom;
            end else begin
                case ($urandom_range(3))
                    0: ticks = 32'h7FFF_FFFF;
                    1: ticks = 32'h8000_0000;
                    2: ticks = 32'hFFFF_FFFF;
                    default: ticks = 32'h7FFF_FFFE;
                endcase
            end
            send_cmd(cmd, id, ticks);
        end
        idle_pct = IDLE_PCT;
    endtask

    // Main sequence.
    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            pool_active[i] = 1'b0;
            pool_count[i] = '0;
        end
        sleep_left = '0;
        for (int i = 0; i < 8; i++) begin
            cmd_count[i] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_pool_full();
        test_random(290);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        // Room for any stray result transaction to show up.
        repeat (SLOTS + 8) @(posedge aclk);

        $display("Covered %0d ticks, %0d allocates, %0d releases, %0d reads, %0d clears,",
                 cmd_count[tcp_pkg::CMD_TICK], cmd_count[tcp_pkg::CMD_ALLOC],
                 cmd_count[tcp_pkg::CMD_RELEASE], cmd_count[tcp_pkg::CMD_READ],
                 cmd_count[tcp_pkg::CMD_CLEAR]);
        $display("%0d sleep loads, %0d spare codes; %0d results, %0d full, %0d out of range.",
                 cmd_count[tcp_pkg::CMD_SLEEP], cmd_count[CMD_SPARE_A] + cmd_count[CMD_SPARE_B],
                 checked_count, full_count, range_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
src/tcp_pkg.sv
src/tcp_ram.sv
src/tcp_engine.sv
src/tick_counter_pool_top.sv
sim/tb_tick_counter_pool_top.sv
